// ===== sv/rpg_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the rgb555 palette gradient
package rpg_pkg;

    localparam int MAX_STEPS = 64;
    localparam int CH_W      = 5;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int CNT_W     = 7;
    localparam int STEP_W    = 6;
    localparam int SUM_W     = $clog2(MAX_STEPS * ((1 << CH_W) - 1) + 1);
    localparam int DIV_STEPS = CH_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // lane control for one cycle
    typedef struct packed {
        logic load;     // latch channels and count, start first division
        logic shift;    // one quotient bit
        logic advance;  // move the sum to the next step, restart division
    } t_lane_ctl;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_STEPS);
        return (c > lim) ? lim : c;
    endfunction

endpackage

// ===== sv/rpg_div_lane.sv =====
`timescale 1ns / 1ps
// one color channel: running weighted sum and bit-serial division by the count
module rpg_div_lane (
    input  logic                    i_clk,
    input  rpg_pkg::t_lane_ctl      i_ctl,
    input  logic [rpg_pkg::CH_W-1:0]  i_ca,
    input  logic [rpg_pkg::CH_W-1:0]  i_cb,
    input  logic [rpg_pkg::CNT_W-1:0] i_n,
    output logic [rpg_pkg::CH_W-1:0]  o_quot
);
    import rpg_pkg::*;

    logic [CH_W-1:0]  r_ca;
    logic [CH_W-1:0]  r_cb;
    logic [CNT_W-1:0] r_n;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dvs;
    logic [CH_W-1:0]  r_q;

    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] load_prod;
    logic [SUM_W-1:0] load_dvs;
    logic [SUM_W-1:0] held_dvs;
    logic             ge;

    // step 0 sum is n*ca, each later step adds cb-ca
    assign load_prod = SUM_W'(i_n) * SUM_W'(i_ca);
    assign load_dvs  = SUM_W'(i_n) << (DIV_STEPS - 1);
    assign held_dvs  = SUM_W'(r_n) << (DIV_STEPS - 1);
    assign n_sum     = r_sum + SUM_W'(r_cb) - SUM_W'(r_ca);
    assign ge        = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ca  <= i_ca;
            r_cb  <= i_cb;
            r_n   <= i_n;
            r_sum <= load_prod;
            r_rem <= load_prod;
            r_dvs <= load_dvs;
        end else if (i_ctl.shift) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_q   <= {r_q[CH_W-2:0], ge};
            r_dvs <= r_dvs >> 1;
        end else if (i_ctl.advance) begin
            r_sum <= n_sum;
            r_rem <= n_sum;
            r_dvs <= held_dvs;
        end
    end

    assign o_quot = r_q;

endmodule

// ===== sv/rgb555_palette_gradient.sv =====
`timescale 1ns / 1ps
// top level: run sequencer, three channel lanes and output register
// One input beat yields a run of min(count, 64) palette entries, a zero count yields none.
// Each entry comes from bit-serial restoring division by the count (one quotient bit per
// cycle, the three channels side by side), after which the result is loaded into the output
// register when the output is not stalled. The input is stalled from the accepting beat until
// the last entry of the run has gone into the output register; the output register keeps the
// last entry while the next input beat is taken.
module rgb555_palette_gradient (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rpg_pkg::COLOR_W-1:0]   i_color_a,
    input  logic [rpg_pkg::COLOR_W-1:0]   i_color_b,
    input  logic [rpg_pkg::CNT_W-1:0]     i_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rpg_pkg::COLOR_W-1:0]   o_color,
    output logic [rpg_pkg::STEP_W-1:0]    o_step_index,
    output logic                          o_last
);
    import rpg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [DCNT_W-1:0]   r_cnt;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_n;
    logic                r_out_valid;
    logic [COLOR_W-1:0]  r_color;
    logic [STEP_W-1:0]   r_out_step;
    logic                r_out_last;

    logic [CNT_W-1:0]    cnt_clamped;
    logic                in_take;
    logic                out_free;
    logic                out_load;
    logic                is_last;
    t_lane_ctl           lane_ctl;
    logic [CH_W-1:0]     q_r;
    logic [CH_W-1:0]     q_g;
    logic [CH_W-1:0]     q_b;

    assign cnt_clamped = clamp_count(i_count);
    assign o_stall     = (r_state != S_IDLE);
    assign in_take     = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign out_load    = (r_state == S_EMIT) && out_free;
    assign is_last     = ({1'b0, r_step} == (r_n - CNT_W'(1)));

    always_comb begin
        lane_ctl         = '0;
        lane_ctl.load    = in_take && (cnt_clamped != '0);
        lane_ctl.shift   = (r_state == S_DIV);
        lane_ctl.advance = (r_state == S_EMIT) && out_free && !is_last;
    end

    rpg_div_lane u_lane_r (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_ca   (i_color_a[CH_W-1:0]),
        .i_cb   (i_color_b[CH_W-1:0]),
        .i_n    (cnt_clamped),
        .o_quot (q_r)
    );

    rpg_div_lane u_lane_g (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_ca   (i_color_a[2*CH_W-1:CH_W]),
        .i_cb   (i_color_b[2*CH_W-1:CH_W]),
        .i_n    (cnt_clamped),
        .o_quot (q_g)
    );

    rpg_div_lane u_lane_b (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_ca   (i_color_a[3*CH_W-1:2*CH_W]),
        .i_cb   (i_color_b[3*CH_W-1:2*CH_W]),
        .i_n    (cnt_clamped),
        .o_quot (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat taken and not refilled this cycle
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (lane_ctl.load) begin
                        r_n     <= cnt_clamped;
                        r_step  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + DCNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_color     <= {q_b, q_g, q_r};
                        r_out_step  <= r_step;
                        r_out_last  <= is_last;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step  <= r_step + STEP_W'(1);
                            r_state <= S_DIV;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_color      = r_color;
    assign o_step_index = r_out_step;
    assign o_last       = r_out_last;

    // division counter never passes the quotient width
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DCNT_W'(DIV_STEPS - 1)))
        else $error("division counter out of range");

    // a run in flight always has a legal clamped count
    a_run_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_n != '0) && (r_n <= CNT_W'(MAX_STEPS))))
        else $error("run count out of range");

    // step index stays inside the run
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ({1'b0, r_step} < r_n))
        else $error("step index beyond run");

    // emitting the last entry ends the run and marks it
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && out_free && is_last) |=>
            ((r_state == S_IDLE) && o_valid && o_last))
        else $error("run did not end on last entry");

endmodule
